// ----- design/sslm_pkg.sv -----
// Package with shared constants of the staging slot lease manager.
`timescale 1ns / 1ps
package sslm_pkg;
    localparam int MaxSlotsDefault = 16;

    localparam logic [2:0] FUNC_ALLOC_WRITE   = 3'd0;
    localparam logic [2:0] FUNC_COMMIT_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_ALLOC_READ    = 3'd2;
    localparam logic [2:0] FUNC_RELEASE_READ  = 3'd3;
    localparam logic [2:0] FUNC_RELEASE_WRITE = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_STORE     = 3'd4;
    localparam logic [2:0] ST_SIZE_OVER = 3'd5;
    localparam logic [2:0] ST_OFFSET    = 3'd6;

    localparam logic [2:0] REG_TIMEOUT     = 3'd0;
    localparam logic [2:0] REG_WRITE_BYTES = 3'd1;
    localparam logic [2:0] REG_READ_BYTES  = 3'd2;
    localparam logic [2:0] REG_READ_BASE   = 3'd3;
    localparam logic [2:0] REG_WRITE_USED  = 3'd4;
    localparam logic [2:0] REG_READ_USED   = 3'd5;

    localparam logic [31:0] LEASE_FIRST = 32'd1;
endpackage

// ----- design/staging_slot_lease_manager_unit.sv -----
// Top level of the staging slot lease manager.
`timescale 1ns / 1ps
// The result word is registered after its request word is accepted: the slot row is read
// at acceptance, then come the match and pick, the offset product and the result register.
// One request is in flight at a time and the next is taken as the result word leaves; a
// stalled result holds off the next request. Synchronous active-low reset clears all busy
// bits, sets the lease counter to one and loads the register defaults; slot contents stay
// undefined until written.
module staging_slot_lease_manager_unit #(
    parameter int MAX_SLOTS = sslm_pkg::MaxSlotsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata bits: func[2:0], req_size, req_lease, req_offset, req_store, now_ms,
    // zero fill to 144 bits
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata bits: status[2:0], slot_offset, granted_lease, ttl_ms, reclaimed,
    // zero fill to 104 bits
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_PICK, S_CALC, S_OUT} t_state;

    // Configuration registers.
    logic [15:0] r_timeout_s;
    logic [31:0] r_wbytes, r_rbytes, r_rbase;
    logic [4:0]  r_wused, r_rused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_s <= 16'd30;
            r_wbytes    <= 32'd1048576;
            r_rbytes    <= 32'd1048576;
            r_rbase     <= 32'd16777216;
            r_wused     <= 5'd16;
            r_rused     <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sslm_pkg::REG_TIMEOUT:     r_timeout_s <= i_cfg_data[15:0];
                sslm_pkg::REG_WRITE_BYTES: r_wbytes    <= i_cfg_data;
                sslm_pkg::REG_READ_BYTES:  r_rbytes    <= i_cfg_data;
                sslm_pkg::REG_READ_BASE:   r_rbase     <= i_cfg_data;
                sslm_pkg::REG_WRITE_USED:  r_wused     <= i_cfg_data[4:0];
                sslm_pkg::REG_READ_USED:   r_rused     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Request fields.
    logic [2:0]  r_func;
    logic [31:0] r_size, r_lease_q, r_offs, r_now;
    logic [7:0]  r_store;

    // Slot memories, one word per slot; both pools share the index space.
    logic [31:0] mem_wlease [MAX_SLOTS];
    logic [31:0] mem_wsize  [MAX_SLOTS];
    logic [31:0] mem_wtime  [MAX_SLOTS];
    logic [31:0] mem_rlease [MAX_SLOTS];
    logic [31:0] mem_rtime  [MAX_SLOTS];
    // The lookup needs every slot at once, so the memory is read as a full
    // row: the registered copy below is the read port.
    logic [31:0] r_rd_lease [MAX_SLOTS];
    logic [31:0] r_rd_time  [MAX_SLOTS];
    logic [31:0] r_rd_wsize [MAX_SLOTS];

    logic [MAX_SLOTS-1:0] r_wbusy, r_rbusy;
    logic [31:0] r_counter;
    t_state      r_state;

    // Derived limits.
    logic [25:0] timeout_ms;
    logic [15:0] tsec;
    logic [CW-1:0] nw, nr, n_sel;
    assign tsec = (r_timeout_s == 16'd0) ? 16'd1 : r_timeout_s;
    assign timeout_ms = 26'(tsec * 26'd1000);
    assign nw = (r_wused == 5'd0) ? CW'(1) : (32'(r_wused) > MAX_SLOTS) ?
                CW'(MAX_SLOTS) : CW'(r_wused);
    assign nr = (r_rused == 5'd0) ? CW'(1) : (32'(r_rused) > MAX_SLOTS) ?
                CW'(MAX_SLOTS) : CW'(r_rused);

    logic is_wpool;
    assign is_wpool = (r_func != sslm_pkg::FUNC_ALLOC_READ) &&
                      (r_func != sslm_pkg::FUNC_RELEASE_READ);
    assign n_sel = is_wpool ? nw : nr;

    logic [MAX_SLOTS-1:0] busy_sel, expired, match, free_after;
    always_comb begin
        busy_sel = is_wpool ? r_wbusy : r_rbusy;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            logic [31:0] age;
            logic in_rng;
            age = r_now - r_rd_time[i];
            in_rng = (CW'(i) < n_sel);
            expired[i] = in_rng && busy_sel[i] && (age > 32'(timeout_ms));
            match[i]   = in_rng && busy_sel[i] && (r_rd_lease[i] == r_lease_q);
            free_after[i] = in_rng && !(busy_sel[i] && !expired[i]);
        end
    end

    // Lowest-set picks.
    logic [IW-1:0] free_idx, match_idx;
    logic          free_any, match_any;
    logic [CW-1:0] exp_cnt;
    always_comb begin
        free_idx = '0; match_idx = '0; free_any = 1'b0; match_any = 1'b0;
        exp_cnt = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (free_after[i]) begin free_idx = IW'(i); free_any = 1'b1; end
            if (match[i]) begin match_idx = IW'(i); match_any = 1'b1; end
        end
        for (int i = 0; i < MAX_SLOTS; i++) exp_cnt = exp_cnt + CW'(expired[i]);
    end

    logic is_alloc, size_bad;
    logic [31:0] cap;
    assign is_alloc = (r_func == sslm_pkg::FUNC_ALLOC_WRITE) ||
                      (r_func == sslm_pkg::FUNC_ALLOC_READ);
    assign cap = is_wpool ? r_wbytes : r_rbytes;
    assign size_bad = (r_size == 32'd0) || (r_size > cap);

    // Busy vectors and pick outcome after the match and pick cycle.
    logic [MAX_SLOTS-1:0] n_wbusy, n_rbusy;
    logic                 n_grant, n_hit;
    logic [4:0]           n_recl;
    always_comb begin
        n_wbusy = r_wbusy;
        n_rbusy = r_rbusy;
        n_grant = 1'b0;
        n_hit   = 1'b0;
        n_recl  = 5'd0;
        if (is_alloc) begin
            if (!size_bad) begin
                // Expired slots are freed before the lowest free one is taken.
                n_recl  = 5'(exp_cnt);
                n_grant = free_any;
                n_hit   = free_any;
                if (is_wpool) begin
                    n_wbusy = r_wbusy & ~expired;
                    if (free_any) n_wbusy[free_idx] = 1'b1;
                end else begin
                    n_rbusy = r_rbusy & ~expired;
                    if (free_any) n_rbusy[free_idx] = 1'b1;
                end
            end
        end else begin
            // Commit and release both free the matching slot.
            n_hit = match_any;
            if (match_any) begin
                if (is_wpool) n_wbusy[match_idx] = 1'b0;
                else          n_rbusy[match_idx] = 1'b0;
            end
        end
    end

    // Pick results, registered for the offset multiply.
    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [31:0]   r_prod, r_alloc_sz;
    logic [2:0]    r_status;
    logic [31:0]   r_soff, r_glease;
    logic [25:0]   r_ttl;
    logic [4:0]    r_recl;
    logic          r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wbusy   <= '0;
            r_rbusy   <= '0;
            r_counter <= sslm_pkg::LEASE_FIRST;
            r_ovalid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (m_axis_tready) r_ovalid <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready &&
                        s_axis_tdata[2:0] <= sslm_pkg::FUNC_RELEASE_WRITE) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_hit   <= n_hit;
                    r_recl  <= n_recl;
                    r_wbusy <= n_wbusy;
                    r_rbusy <= n_rbusy;
                    r_idx   <= is_alloc ? free_idx : match_idx;
                    if (n_grant) begin
                        if (is_wpool) begin
                            mem_wlease[free_idx] <= r_counter;
                            mem_wtime[free_idx]  <= r_now;
                            mem_wsize[free_idx]  <= r_size;
                        end else begin
                            mem_rlease[free_idx] <= r_counter;
                            mem_rtime[free_idx]  <= r_now;
                        end
                        r_counter <= r_counter + 32'd1;
                    end
                    r_alloc_sz <= r_rd_wsize[match_idx];
                    r_glease   <= r_counter;
                    r_state    <= S_CALC;
                end
                S_CALC: begin
                    r_prod  <= 32'(32'(r_idx) * (is_wpool ? r_wbytes : r_rbytes));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (is_alloc) begin
                        if (size_bad || !r_hit) begin
                            r_status <= size_bad ? sslm_pkg::ST_BAD_SIZE
                                                 : sslm_pkg::ST_NO_SLOT;
                            r_soff   <= 32'd0;
                            r_glease <= 32'd0;
                            r_ttl    <= 26'd0;
                        end else begin
                            r_status <= sslm_pkg::ST_OK;
                            r_soff   <= is_wpool ? r_prod : r_rbase + r_prod;
                            r_ttl    <= timeout_ms;
                        end
                    end else begin
                        r_glease <= 32'd0;
                        r_ttl    <= 26'd0;
                        if (r_hit && r_func == sslm_pkg::FUNC_COMMIT_WRITE) begin
                            r_soff <= r_prod;
                            priority if (r_store != 8'd0) r_status <= sslm_pkg::ST_STORE;
                            else if (r_size > r_alloc_sz) r_status <= sslm_pkg::ST_SIZE_OVER;
                            else if (r_offs != r_prod) r_status <= sslm_pkg::ST_OFFSET;
                            else r_status <= sslm_pkg::ST_OK;
                        end else begin
                            r_soff   <= 32'd0;
                            r_status <= r_hit ? sslm_pkg::ST_OK : sslm_pkg::ST_UNKNOWN;
                        end
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Request capture and the row read of the slot memories.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready) begin
            r_func    <= s_axis_tdata[2:0];
            r_size    <= s_axis_tdata[34:3];
            r_lease_q <= s_axis_tdata[66:35];
            r_offs    <= s_axis_tdata[98:67];
            r_store   <= s_axis_tdata[106:99];
            r_now     <= s_axis_tdata[138:107];
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_rd_lease[i] <= (s_axis_tdata[2:0] == sslm_pkg::FUNC_ALLOC_READ ||
                                  s_axis_tdata[2:0] == sslm_pkg::FUNC_RELEASE_READ) ?
                                 mem_rlease[i] : mem_wlease[i];
                r_rd_time[i]  <= (s_axis_tdata[2:0] == sslm_pkg::FUNC_ALLOC_READ) ?
                                 mem_rtime[i] : mem_wtime[i];
                r_rd_wsize[i] <= mem_wsize[i];
            end
        end
    end

    // Accept only when idle and the result register is free or draining.
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_recl, r_ttl, r_glease, r_soff, r_status};

    // The lease counter advances by exactly one on every grant.
    a_busy_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && is_alloc && !size_bad && free_any) |=>
        (r_counter == $past(r_counter) + 32'd1))
        else $error("lease counter did not advance on grant");
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("request accepted while busy");
    a_out_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result without a completed request");
endmodule
